FILE: src/tlshp_pkg.sv
// Package for the handshake hello field parser: parse phases, field kind codes,
// and the parser state and per-byte result structs. No dependencies.
`timescale 1ns / 1ps

package tlshp_pkg;

  // Field kind codes as they appear on the result channel
  localparam logic [3:0] KIND_TYPE    = 4'd0;
  localparam logic [3:0] KIND_LEN     = 4'd1;
  localparam logic [3:0] KIND_VMAJ    = 4'd2;
  localparam logic [3:0] KIND_VMIN    = 4'd3;
  localparam logic [3:0] KIND_RANDOM  = 4'd4;
  localparam logic [3:0] KIND_SIDLEN  = 4'd5;
  localparam logic [3:0] KIND_SID     = 4'd6;
  localparam logic [3:0] KIND_CSLEN   = 4'd7;
  localparam logic [3:0] KIND_CS      = 4'd8;
  localparam logic [3:0] KIND_COMPLEN = 4'd9;
  localparam logic [3:0] KIND_COMP    = 4'd10;
  localparam logic [3:0] KIND_EXTLEN  = 4'd11;
  localparam logic [3:0] KIND_BODY    = 4'd12;

  localparam logic [7:0]  CLIENT_HELLO_TYPE = 8'd1;
  localparam logic [15:0] RANDOM_LAST       = 16'd31;  // 32 random bytes
  localparam logic [15:0] LEN_LAST          = 16'd2;   // 3 length bytes
  localparam logic [15:0] POS_MAX           = 16'hFFFF;

  typedef enum logic [12:0] {
    PH_TYPE    = 13'h0001,
    PH_LEN     = 13'h0002,
    PH_VMAJ    = 13'h0004,
    PH_VMIN    = 13'h0008,
    PH_RANDOM  = 13'h0010,
    PH_SIDLEN  = 13'h0020,
    PH_SID     = 13'h0040,
    PH_CSLEN   = 13'h0080,
    PH_CS      = 13'h0100,
    PH_COMPLEN = 13'h0200,
    PH_COMP    = 13'h0400,
    PH_EXTLEN  = 13'h0800,
    PH_BODY    = 13'h1000
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [15:0] pos;
    logic [15:0] pend;
    logic [7:0]  ktype;
    logic [23:0] klen;
  } parse_state_t;

  typedef struct packed {
    logic [3:0]  field_kind;
    logic [7:0]  byte_value;
    logic [15:0] index_in_field;
    logic        field_complete;
    logic [7:0]  message_kind;
    logic [23:0] message_length;
    logic        truncated;
  } field_result_t;

endpackage

FILE: src/tlshp_step.sv
// Per-byte labelling logic: next parser state and the result for one byte.
// Purely combinational; uses tlshp_pkg.
`timescale 1ns / 1ps

module tlshp_step (
  input  tlshp_pkg::parse_state_t  st,
  input  logic [7:0]               data_byte,
  input  logic                     sof,
  input  logic                     eof,
  output tlshp_pkg::parse_state_t  st_nxt,
  output tlshp_pkg::field_result_t res
);

  tlshp_pkg::phase_t ph;
  logic [15:0]       pos;
  logic [15:0]       pend;
  logic [15:0]       cs_len;
  logic [16:0]       pos_inc;
  logic              len_done;
  logic [3:0]        kind;
  logic              done;
  logic              trunc;

  always_comb begin
    // start of message restarts parsing before this byte is labelled
    ph   = sof ? tlshp_pkg::PH_TYPE : st.phase;
    pos  = sof ? 16'd0 : st.pos;
    pend = sof ? 16'd0 : st.pend;

    pos_inc  = {1'b0, pos} + 17'd1;
    len_done = pos_inc >= {1'b0, pend};
    cs_len   = {pend[7:0], data_byte};

    st_nxt       = st;
    st_nxt.phase = ph;
    st_nxt.pos   = pos;
    st_nxt.pend  = pend;
    kind         = tlshp_pkg::KIND_BODY;
    done         = 1'b0;

    unique case (ph)
      tlshp_pkg::PH_TYPE: begin
        kind         = tlshp_pkg::KIND_TYPE;
        st_nxt.ktype = data_byte;
        st_nxt.klen  = 24'd0;
        done         = 1'b1;
        st_nxt.phase = tlshp_pkg::PH_LEN;
        st_nxt.pos   = 16'd0;
      end
      tlshp_pkg::PH_LEN: begin
        kind        = tlshp_pkg::KIND_LEN;
        st_nxt.klen = {st.klen[15:0], data_byte};
        if (pos >= tlshp_pkg::LEN_LAST) begin
          done         = 1'b1;
          st_nxt.phase = (st.ktype == tlshp_pkg::CLIENT_HELLO_TYPE) ?
                         tlshp_pkg::PH_VMAJ : tlshp_pkg::PH_BODY;
          st_nxt.pos   = 16'd0;
        end else begin
          st_nxt.pos = pos_inc[15:0];
        end
      end
      tlshp_pkg::PH_VMAJ: begin
        kind         = tlshp_pkg::KIND_VMAJ;
        done         = 1'b1;
        st_nxt.phase = tlshp_pkg::PH_VMIN;
      end
      tlshp_pkg::PH_VMIN: begin
        kind         = tlshp_pkg::KIND_VMIN;
        done         = 1'b1;
        st_nxt.phase = tlshp_pkg::PH_RANDOM;
        st_nxt.pos   = 16'd0;
      end
      tlshp_pkg::PH_RANDOM: begin
        kind = tlshp_pkg::KIND_RANDOM;
        if (pos >= tlshp_pkg::RANDOM_LAST) begin
          done         = 1'b1;
          st_nxt.phase = tlshp_pkg::PH_SIDLEN;
          st_nxt.pos   = 16'd0;
        end else begin
          st_nxt.pos = pos_inc[15:0];
        end
      end
      tlshp_pkg::PH_SIDLEN: begin
        kind         = tlshp_pkg::KIND_SIDLEN;
        st_nxt.pend  = {8'd0, data_byte};
        done         = 1'b1;
        st_nxt.phase = (data_byte != 8'd0) ? tlshp_pkg::PH_SID : tlshp_pkg::PH_CSLEN;
        st_nxt.pos   = 16'd0;
      end
      tlshp_pkg::PH_COMPLEN: begin
        kind         = tlshp_pkg::KIND_COMPLEN;
        st_nxt.pend  = {8'd0, data_byte};
        done         = 1'b1;
        st_nxt.phase = (data_byte != 8'd0) ? tlshp_pkg::PH_COMP : tlshp_pkg::PH_EXTLEN;
        st_nxt.pos   = 16'd0;
      end
      tlshp_pkg::PH_SID: begin
        kind = tlshp_pkg::KIND_SID;
        if (len_done) begin
          done         = 1'b1;
          st_nxt.phase = tlshp_pkg::PH_CSLEN;
          st_nxt.pos   = 16'd0;
        end else begin
          st_nxt.pos = pos_inc[15:0];
        end
      end
      tlshp_pkg::PH_CS: begin
        kind = tlshp_pkg::KIND_CS;
        if (len_done) begin
          done         = 1'b1;
          st_nxt.phase = tlshp_pkg::PH_COMPLEN;
          st_nxt.pos   = 16'd0;
        end else begin
          st_nxt.pos = pos_inc[15:0];
        end
      end
      tlshp_pkg::PH_COMP: begin
        kind = tlshp_pkg::KIND_COMP;
        if (len_done) begin
          done         = 1'b1;
          st_nxt.phase = tlshp_pkg::PH_EXTLEN;
          st_nxt.pos   = 16'd0;
        end else begin
          st_nxt.pos = pos_inc[15:0];
        end
      end
      tlshp_pkg::PH_CSLEN: begin
        kind = tlshp_pkg::KIND_CSLEN;
        if (pos == 16'd0) begin
          st_nxt.pend = {8'd0, data_byte};
          st_nxt.pos  = 16'd1;
        end else begin
          st_nxt.pend  = cs_len;
          done         = 1'b1;
          st_nxt.phase = (cs_len != 16'd0) ? tlshp_pkg::PH_CS : tlshp_pkg::PH_COMPLEN;
          st_nxt.pos   = 16'd0;
        end
      end
      tlshp_pkg::PH_EXTLEN: begin
        kind = tlshp_pkg::KIND_EXTLEN;
        if (pos == 16'd0) begin
          st_nxt.pos = 16'd1;
        end else begin
          done         = 1'b1;
          st_nxt.phase = tlshp_pkg::PH_BODY;
          st_nxt.pos   = 16'd0;
        end
      end
      default: begin
        // body, and any phase code that cannot occur; index saturates
        kind         = tlshp_pkg::KIND_BODY;
        done         = eof;
        st_nxt.phase = tlshp_pkg::PH_BODY;
        if (pos != tlshp_pkg::POS_MAX) begin
          st_nxt.pos = pos_inc[15:0];
        end
      end
    endcase

    trunc = eof && (st_nxt.ktype == tlshp_pkg::CLIENT_HELLO_TYPE) &&
            (st_nxt.phase != tlshp_pkg::PH_BODY);

    res.field_kind     = kind;
    res.byte_value     = data_byte;
    res.index_in_field = pos;
    res.field_complete = done;
    res.message_kind   = st_nxt.ktype;
    res.message_length = st_nxt.klen;
    res.truncated      = trunc;

    // next byte after end of message is a type octet
    if (eof) begin
      st_nxt.phase = tlshp_pkg::PH_TYPE;
      st_nxt.pos   = 16'd0;
      st_nxt.pend  = 16'd0;
    end
  end

endmodule

FILE: src/tls_handshake_hello_field_parser.sv
// Top level of the handshake hello field parser: input register, parser state,
// output register. Uses tlshp_pkg and tlshp_step.
`timescale 1ns / 1ps

// Channel | Handshake             | Payload
// in_     | in_valid / in_ready   | data_byte, start_of_message, end_of_message
// out_    | out_valid / out_ready | field_kind .. truncated, one transfer per byte
//
// One byte per cycle sustained while out_ready stays high; a byte's label passes
// through the input register and then the output register to reach the outputs.
// The labelling logic sits between the input register and the output register,
// and the parser state advances when a byte moves from one to the other.
// Reset (rst_n low, synchronous) empties both registers and returns the parser to
// expecting a type octet. A stall on out_ready holds both registers; in_ready
// stays high while the input register is empty or moving forward.
module tls_handshake_hello_field_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_start_of_message,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_field_kind,
  output logic [7:0]  out_byte_value,
  output logic [15:0] out_index_in_field,
  output logic        out_field_complete,
  output logic [7:0]  out_message_kind,
  output logic [23:0] out_message_length,
  output logic        out_truncated
);

  logic                     in_vld_r;
  logic                     in_vld_nxt;
  logic [7:0]               data_r;
  logic                     sof_r;
  logic                     eof_r;
  logic                     out_vld_r;
  logic                     out_vld_nxt;
  logic                     advance;
  tlshp_pkg::parse_state_t  st_r;
  tlshp_pkg::parse_state_t  st_nxt;
  tlshp_pkg::field_result_t res;
  tlshp_pkg::field_result_t out_r;

  assign advance  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;

  tlshp_step u_step (
    .st        (st_r),
    .data_byte (data_r),
    .sof       (sof_r),
    .eof       (eof_r),
    .st_nxt    (st_nxt),
    .res       (res)
  );

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_valid && in_ready) begin
      in_vld_nxt = 1'b1;
    end else if (advance) begin
      in_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (advance) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
      st_r.phase <= tlshp_pkg::PH_TYPE;
      st_r.pos   <= 16'd0;
      st_r.pend  <= 16'd0;
      st_r.ktype <= 8'd0;
      st_r.klen  <= 24'd0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (advance) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_data_byte;
      sof_r  <= in_start_of_message;
      eof_r  <= in_end_of_message;
    end
    if (advance) begin
      out_r <= res;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_field_kind     = out_r.field_kind;
  assign out_byte_value     = out_r.byte_value;
  assign out_index_in_field = out_r.index_in_field;
  assign out_field_complete = out_r.field_complete;
  assign out_message_kind   = out_r.message_kind;
  assign out_message_length = out_r.message_length;
  assign out_truncated      = out_r.truncated;

endmodule

FILE: sim/tlshp_field_checker.sv
// Checker for the handshake hello field parser: watches both channels, labels every
// accepted byte with its own parser model and compares each result transfer.
// Depends on tlshp_pkg for the field kind codes and the result struct.
`timescale 1ns / 1ps

module tlshp_field_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_start_of_message,
  input  logic        in_end_of_message,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [3:0]  out_field_kind,
  input  logic [7:0]  out_byte_value,
  input  logic [15:0] out_index_in_field,
  input  logic        out_field_complete,
  input  logic [7:0]  out_message_kind,
  input  logic [23:0] out_message_length,
  input  logic        out_truncated,
  output int          fail_count,
  output int          expected_left
);

  localparam int REPORT_LIMIT = 40;

  // model parser state; the phase is held as the field kind code it labels
  logic [3:0]               phase;
  logic [15:0]              pos;
  logic [15:0]              pend;
  logic [7:0]               kept_kind;
  logic [23:0]              kept_len;
  tlshp_pkg::field_result_t label_q[$];
  int                       errors = 0;

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= REPORT_LIMIT) $display("%0t ns: %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic [23:0] got,
                             input logic [23:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
  endtask

  function automatic tlshp_pkg::field_result_t label_byte(input logic [7:0] b,
                                                          input logic som,
                                                          input logic eom);
    tlshp_pkg::field_result_t r;
    logic                     done;
    if (som) begin
      phase = tlshp_pkg::KIND_TYPE;
      pos   = '0;
      pend  = '0;
    end
    if (phase > tlshp_pkg::KIND_BODY) phase = tlshp_pkg::KIND_BODY;
    r.field_kind     = phase;
    r.index_in_field = pos;
    done = 1'b0;
    case (phase) inside
      tlshp_pkg::KIND_TYPE: begin
        kept_kind = b;
        kept_len  = '0;
        done      = 1'b1;
        phase     = tlshp_pkg::KIND_LEN;
        pos       = '0;
      end
      tlshp_pkg::KIND_LEN: begin
        kept_len = {kept_len[15:0], b};
        if (pos >= tlshp_pkg::LEN_LAST) begin
          done  = 1'b1;
          phase = (kept_kind == tlshp_pkg::CLIENT_HELLO_TYPE) ?
                  tlshp_pkg::KIND_VMAJ : tlshp_pkg::KIND_BODY;
          pos   = '0;
        end else begin
          pos = pos + 16'd1;
        end
      end
      tlshp_pkg::KIND_VMAJ: begin
        done  = 1'b1;
        phase = tlshp_pkg::KIND_VMIN;
      end
      tlshp_pkg::KIND_VMIN: begin
        done  = 1'b1;
        phase = tlshp_pkg::KIND_RANDOM;
        pos   = '0;
      end
      tlshp_pkg::KIND_RANDOM: begin
        if (pos >= tlshp_pkg::RANDOM_LAST) begin
          done  = 1'b1;
          phase = tlshp_pkg::KIND_SIDLEN;
          pos   = '0;
        end else begin
          pos = pos + 16'd1;
        end
      end
      tlshp_pkg::KIND_SIDLEN, tlshp_pkg::KIND_COMPLEN: begin
        pend = {8'd0, b};
        done = 1'b1;
        // zero length skips the field body
        if (phase == tlshp_pkg::KIND_SIDLEN)
          phase = (b != 8'd0) ? tlshp_pkg::KIND_SID : tlshp_pkg::KIND_CSLEN;
        else
          phase = (b != 8'd0) ? tlshp_pkg::KIND_COMP : tlshp_pkg::KIND_EXTLEN;
        pos = '0;
      end
      tlshp_pkg::KIND_SID, tlshp_pkg::KIND_CS, tlshp_pkg::KIND_COMP: begin
        if ({1'b0, pos} + 17'd1 >= {1'b0, pend}) begin
          done  = 1'b1;
          phase = (phase == tlshp_pkg::KIND_SID) ? tlshp_pkg::KIND_CSLEN :
                  (phase == tlshp_pkg::KIND_CS)  ? tlshp_pkg::KIND_COMPLEN :
                  tlshp_pkg::KIND_EXTLEN;
          pos   = '0;
        end else begin
          pos = pos + 16'd1;
        end
      end
      tlshp_pkg::KIND_CSLEN: begin
        if (pos == 16'd0) begin
          pend = {8'd0, b};
          pos  = 16'd1;
        end else begin
          pend  = {pend[7:0], b};
          done  = 1'b1;
          phase = (pend != 16'd0) ? tlshp_pkg::KIND_CS : tlshp_pkg::KIND_COMPLEN;
          pos   = '0;
        end
      end
      tlshp_pkg::KIND_EXTLEN: begin
        if (pos == 16'd0) begin
          pos = 16'd1;
        end else begin
          done  = 1'b1;
          phase = tlshp_pkg::KIND_BODY;
          pos   = '0;
        end
      end
      default: begin
        done = eom;
        if (pos < tlshp_pkg::POS_MAX) pos = pos + 16'd1;
      end
    endcase
    r.truncated = eom && (kept_kind == tlshp_pkg::CLIENT_HELLO_TYPE) &&
                  (phase != tlshp_pkg::KIND_BODY);
    if (eom) begin
      phase = tlshp_pkg::KIND_TYPE;
      pos   = '0;
      pend  = '0;
    end
    r.byte_value     = b;
    r.field_complete = done;
    r.message_kind   = kept_kind;
    r.message_length = kept_len;
    return r;
  endfunction

  always @(posedge clk) begin
    tlshp_pkg::field_result_t want;
    if (!rst_n) begin
      phase     = tlshp_pkg::KIND_TYPE;
      pos       = '0;
      pend      = '0;
      kept_kind = '0;
      kept_len  = '0;
      label_q.delete();
    end else begin
      // check before labelling: a result can never belong to this edge's byte
      if (out_valid && out_ready) begin
        if (label_q.size() == 0) begin
          report_mismatch($sformatf("result transfer with no byte pending, byte %02h",
                                    out_byte_value));
        end else begin
          want = label_q.pop_front();
          check_field("field_kind", 24'(out_field_kind), 24'(want.field_kind));
          check_field("byte_value", 24'(out_byte_value), 24'(want.byte_value));
          check_field("index_in_field", 24'(out_index_in_field),
                      24'(want.index_in_field));
          check_field("field_complete", 24'(out_field_complete),
                      24'(want.field_complete));
          check_field("message_kind", 24'(out_message_kind), 24'(want.message_kind));
          check_field("message_length", out_message_length, want.message_length);
          check_field("truncated", 24'(out_truncated), 24'(want.truncated));
        end
      end
      if (in_valid && in_ready)
        label_q.push_back(label_byte(in_data_byte, in_start_of_message,
                                     in_end_of_message));
    end
    fail_count    <= errors;
    expected_left <= label_q.size();
  end

endmodule

FILE: sim/tb_tls_handshake_hello_field_parser.sv
// Top of the handshake hello field parser testbench: clock, reset, byte stream
// stimulus, result-side backpressure and the verdict. Uses tlshp_pkg, the parser
// and tlshp_field_checker.
`timescale 1ns / 1ps

module tb_tls_handshake_hello_field_parser;

  localparam int CYCLE_LIMIT  = 1_000_000;
  // the directed part adds roughly another 500 bytes
  localparam int RANDOM_ITEMS = 410;
  localparam int RANDOM_BYTES = 32;
  localparam int LONG_HOLD    = 150;
  localparam int SETTLE       = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       som;
    logic       eom;
  } beat_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_data_byte;
  logic        in_start_of_message;
  logic        in_end_of_message;
  logic        out_valid;
  logic        out_ready;
  logic [3:0]  out_field_kind;
  logic [7:0]  out_byte_value;
  logic [15:0] out_index_in_field;
  logic        out_field_complete;
  logic [7:0]  out_message_kind;
  logic [23:0] out_message_length;
  logic        out_truncated;

  int    fail_count;
  int    expected_left;
  int    cycle_count;
  int    hold_requests;
  int    random_sent;
  bit    sender_gaps;
  bit    stall_enable;
  beat_t msg_q[$];

  tls_handshake_hello_field_parser u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_data_byte       (in_data_byte),
    .in_start_of_message(in_start_of_message),
    .in_end_of_message  (in_end_of_message),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_field_kind     (out_field_kind),
    .out_byte_value     (out_byte_value),
    .out_index_in_field (out_index_in_field),
    .out_field_complete (out_field_complete),
    .out_message_kind   (out_message_kind),
    .out_message_length (out_message_length),
    .out_truncated      (out_truncated)
  );

  tlshp_field_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_data_byte       (in_data_byte),
    .in_start_of_message(in_start_of_message),
    .in_end_of_message  (in_end_of_message),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_field_kind     (out_field_kind),
    .out_byte_value     (out_byte_value),
    .out_index_in_field (out_index_in_field),
    .out_field_complete (out_field_complete),
    .out_message_kind   (out_message_kind),
    .out_message_length (out_message_length),
    .out_truncated      (out_truncated),
    .fail_count         (fail_count),
    .expected_left      (expected_left)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // mostly short idle stretches, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result side: random stalls, plus a long hold-off on request
  initial begin
    int stall_left;
    int hold_seen;
    out_ready  = 1'b0;
    stall_left = 0;
    hold_seen  = 0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_requests) begin
        hold_seen  = hold_requests;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && stall_enable && $urandom_range(0, 99) < 20) begin
        stall_left = idle_len();
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic push_beat(input logic [7:0] data, input logic som, input logic eom);
    beat_t bt;
    bt.data = data;
    bt.som  = som;
    bt.eom  = eom;
    msg_q.push_back(bt);
  endtask

  task automatic push_random(input int count);
    repeat (count) push_beat(8'($urandom), 1'b0, 1'b0);
  endtask

  task automatic build_client_hello(input logic [7:0] sid_len, input logic [15:0] cs_len,
                                    input logic [7:0] comp_len, input int body_len);
    msg_q.delete();
    push_beat(tlshp_pkg::CLIENT_HELLO_TYPE, 1'b0, 1'b0);
    push_random(3 + 2 + RANDOM_BYTES);  // length, version, random
    push_beat(sid_len, 1'b0, 1'b0);
    push_random(int'(sid_len));
    push_beat(cs_len[15:8], 1'b0, 1'b0);
    push_beat(cs_len[7:0], 1'b0, 1'b0);
    push_random(int'(cs_len));
    push_beat(comp_len, 1'b0, 1'b0);
    push_random(int'(comp_len));
    push_random(2 + body_len);          // extensions length, then body
  endtask

  task automatic build_other(input logic [7:0] kind, input int body_len);
    msg_q.delete();
    push_beat(kind, 1'b0, 1'b0);
    push_random(3 + body_len);
  endtask

  task automatic send_beat(input beat_t bt);
    int gap;
    gap = 0;
    if (sender_gaps && $urandom_range(0, 99) < 25) gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_data_byte        <= bt.data;
    in_start_of_message <= bt.som;
    in_end_of_message   <= bt.eom;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_message(input bit with_som, input bit with_eom);
    beat_t bt;
    int    i;
    for (i = 0; i < msg_q.size(); i++) begin
      bt = msg_q[i];
      if (i == 0 && with_som) bt.som = 1'b1;
      if (i == msg_q.size() - 1 && with_eom) bt.eom = 1'b1;
      send_beat(bt);
    end
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_left != 0);
  endtask

  initial begin
    int          r;
    int          cut;
    logic [7:0]  sid_len;
    logic [15:0] cs_len;
    logic [7:0]  comp_len;
    logic [7:0]  kind;
    rst_n               = 1'b0;
    in_valid            = 1'b0;
    in_data_byte        = 8'd0;
    in_start_of_message = 1'b0;
    in_end_of_message   = 1'b0;
    stall_enable        = 1'b0;
    hold_requests       = 0;
    random_sent         = 0;
    sender_gaps         = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: one-byte messages, header-only end, type without start flag,
    // restart in the middle of a hello, end inside the length
    sender_gaps = 1'b1;
    stall_enable <= 1'b1;
    msg_q.delete();
    push_beat(tlshp_pkg::CLIENT_HELLO_TYPE, 1'b1, 1'b1);
    push_beat(8'h00, 1'b1, 1'b1);
    push_beat(8'hFE, 1'b1, 1'b0); push_beat(8'h12, 1'b0, 1'b0);
    push_beat(8'h34, 1'b0, 1'b1);
    push_beat(8'hFF, 1'b0, 1'b0); push_beat(8'hFF, 1'b0, 1'b0);
    push_beat(8'h00, 1'b0, 1'b0); push_beat(8'hFF, 1'b0, 1'b0);
    push_beat(8'hAA, 1'b0, 1'b0); push_beat(8'h55, 1'b0, 1'b1);
    push_beat(tlshp_pkg::CLIENT_HELLO_TYPE, 1'b1, 1'b0); push_beat(8'h00, 1'b0, 1'b0);
    push_beat(8'h00, 1'b0, 1'b0); push_beat(8'h30, 1'b0, 1'b0);
    push_beat(8'h03, 1'b0, 1'b0);
    push_beat(tlshp_pkg::CLIENT_HELLO_TYPE, 1'b1, 1'b0); push_beat(8'hFF, 1'b0, 1'b0);
    push_beat(8'hFF, 1'b0, 1'b0); push_beat(8'hFF, 1'b0, 1'b1);
    send_message(1'b0, 1'b0);
    wait_drain();

    // field extremes: all lengths zero, cipher suite length with its high byte set,
    // a longer body
    build_client_hello(8'd0, 16'd0, 8'd0, 0);
    send_message(1'b1, 1'b1);
    sender_gaps = 1'b0;
    stall_enable <= 1'b0;
    build_client_hello(8'h20, 16'h0100, 8'h03, 3);
    send_message(1'b1, 1'b1);
    build_other(8'hFF, 20);
    send_message(1'b1, 1'b1);
    wait_drain();

    // long result-side hold-off while the sender keeps offering bytes
    stall_enable <= 1'b1;
    build_client_hello(8'd4, 16'd6, 8'd1, 10);
    hold_requests <= hold_requests + 1;
    send_message(1'b1, 1'b1);
    wait_drain();

    while (random_sent < RANDOM_ITEMS) begin
      sender_gaps = ($urandom_range(0, 3) != 0);
      stall_enable <= ($urandom_range(0, 3) != 0);
      r = $urandom_range(0, 99);
      if (r < 65) begin
        r        = $urandom_range(0, 99);
        sid_len  = (r < 20) ? 8'd0 : (r < 92) ? 8'($urandom_range(1, 8)) : 8'd32;
        r        = $urandom_range(0, 99);
        cs_len   = (r < 20) ? 16'd0 :
                   (r < 94) ? 16'($urandom_range(1, 12)) : 16'($urandom_range(256, 259));
        comp_len = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(1, 3));
        build_client_hello(sid_len, cs_len, comp_len, $urandom_range(0, 6));
        if ($urandom_range(0, 4) == 0) begin
          cut = $urandom_range(1, msg_q.size() - 1);
          while (msg_q.size() > cut) void'(msg_q.pop_back());
        end
        if ($urandom_range(0, 11) == 0) begin
          hold_requests <= hold_requests + 1;
          sender_gaps = 1'b0;
        end
        send_message($urandom_range(0, 9) != 0, 1'b1);
      end else if (r < 85) begin
        do kind = 8'($urandom); while (kind == tlshp_pkg::CLIENT_HELLO_TYPE);
        build_other(kind, $urandom_range(0, 8));
        send_message($urandom_range(0, 9) != 0, 1'b1);
      end else begin
        // noise: stray start and end flags anywhere
        msg_q.delete();
        repeat ($urandom_range(1, 12))
          push_beat(8'($urandom), $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0);
        send_message(1'($urandom), 1'($urandom));
      end
      random_sent += msg_q.size();
      if ($urandom_range(0, 7) == 0) wait_drain();
    end

    wait_drain();
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
